### rtl/frbc_pkg.sv
// Shared types, constants and the instruction decoder of the four-register byte CPU.
package frbc_pkg;

    // Width of a register and of the operand buses.
    localparam int DATA_W = 8;

    // Number of shift steps of the multiply and divide unit, and its counter width.
    localparam int ITER_STEPS = DATA_W;
    localparam int STEP_CNT_W = $clog2(ITER_STEPS);

    // Register file depth and address width.
    localparam int RF_DEPTH  = 4;
    localparam int RF_ADDR_W = $clog2(RF_DEPTH);

    // Register that a move-immediate loads.
    localparam logic [RF_ADDR_W-1:0] MOVI_DST = RF_ADDR_W'(3);

    // Result kinds reported with every beat.
    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_OUT     = 2'd1;
    localparam logic [1:0] KIND_ILLEGAL = 2'd2;

    // Instruction encodings.
    localparam logic [7:0] OPC_ADD    = 8'h80;
    localparam logic [7:0] OPC_SUB    = 8'h90;
    localparam logic [7:0] OPC_MUL    = 8'hA0;
    localparam logic [7:0] OPC_DIV    = 8'hB0;
    localparam logic [7:0] OPC_IN     = 8'hC0;
    localparam logic [7:0] OPC_OUT    = 8'hC4;
    localparam logic [7:0] MASK_ALU   = 8'hF0;
    localparam logic [7:0] MASK_IO    = 8'hFC;

    // Decoded instruction class.
    typedef enum logic [2:0] {
        OP_MOVI,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_IN,
        OP_OUT,
        OP_ILL
    } t_op;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ITER,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic init_iter;
        logic step;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic out_busy;
    } t_dp_stat;

    // Classify one instruction byte.
    function automatic t_op decode(input logic [7:0] instr);
        t_op op;
        op = OP_ILL;
        if (!instr[7]) begin
            op = OP_MOVI;
        end else if ((instr & MASK_ALU) == OPC_ADD) begin
            op = OP_ADD;
        end else if ((instr & MASK_ALU) == OPC_SUB) begin
            op = OP_SUB;
        end else if ((instr & MASK_ALU) == OPC_MUL) begin
            op = OP_MUL;
        end else if ((instr & MASK_ALU) == OPC_DIV) begin
            op = OP_DIV;
        end else if ((instr & MASK_IO) == OPC_IN) begin
            op = OP_IN;
        end else if ((instr & MASK_IO) == OPC_OUT) begin
            op = OP_OUT;
        end
        return op;
    endfunction

endpackage

### rtl/frbc_ctrl.sv
// Controller state machine that sequences fetch, execute, iteration and retire.
module frbc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  frbc_pkg::t_dp_stat i_stat,
    output frbc_pkg::t_dp_cmd  o_cmd
);

    localparam logic [frbc_pkg::STEP_CNT_W-1:0] ITER_LAST =
        frbc_pkg::STEP_CNT_W'(frbc_pkg::ITER_STEPS - 1);

    frbc_pkg::t_state                  r_state, n_state;
    logic [frbc_pkg::STEP_CNT_W-1:0]   r_step_cnt, n_step_cnt;

    // State and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= frbc_pkg::S_IDLE;
            r_step_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_step_cnt <= n_step_cnt;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state    = r_state;
        n_step_cnt = r_step_cnt;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            frbc_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = frbc_pkg::S_EXEC;
                end
            end
            frbc_pkg::S_EXEC: begin
                if (i_stat.op == frbc_pkg::OP_MUL || i_stat.op == frbc_pkg::OP_DIV) begin
                    o_cmd.init_iter = 1'b1;
                    n_step_cnt      = '0;
                    n_state         = frbc_pkg::S_ITER;
                end else begin
                    n_state = frbc_pkg::S_DONE;
                end
            end
            frbc_pkg::S_ITER: begin
                o_cmd.step = 1'b1;
                n_step_cnt = r_step_cnt + 1'b1;
                if (r_step_cnt == ITER_LAST) begin
                    n_state = frbc_pkg::S_DONE;
                end
            end
            frbc_pkg::S_DONE: begin
                // Retire only once the output register can take the result.
                if (!i_stat.out_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = frbc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frbc_pkg::S_IDLE;
            end
        endcase
    end

    // Only multiply and divide run the iterative unit.
    a_iter_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == frbc_pkg::S_ITER |->
            (i_stat.op == frbc_pkg::OP_MUL || i_stat.op == frbc_pkg::OP_DIV))
        else $error("iteration running for a non-iterative op");

    // A result never overwrites a beat that is still held.
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_stat.out_busy)
        else $error("commit while output register is busy");

    // An accepted beat goes straight to execute.
    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == frbc_pkg::S_EXEC)
        else $error("accepted beat not executed");

endmodule

### rtl/frbc_dp.sv
// Datapath: instruction register, register file, iterative multiply/divide and output register.
module frbc_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [7:0]         i_instr_byte,
    input  logic [7:0]         i_in_value,
    input  frbc_pkg::t_dp_cmd  i_cmd,
    output frbc_pkg::t_dp_stat o_stat,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic [1:0]         o_out_kind,
    output logic [7:0]         o_out_value
);

    localparam int W = frbc_pkg::DATA_W;

    logic [7:0]                        r_instr;
    logic [W-1:0]                      r_in_value;
    logic [W-1:0]                      r_rf [frbc_pkg::RF_DEPTH];
    logic [W-1:0]                      r_hi;
    logic [W-1:0]                      r_lo;
    logic [W-1:0]                      r_opnd;
    logic                              r_out_valid;
    logic [1:0]                        r_out_kind;
    logic [W-1:0]                      r_out_value;

    frbc_pkg::t_op                     w_op;
    logic [frbc_pkg::RF_ADDR_W-1:0]    w_dst;
    logic [frbc_pkg::RF_ADDR_W-1:0]    w_src;
    logic [W-1:0]                      w_opa;
    logic [W-1:0]                      w_opb;
    logic [W:0]                        w_shift;
    logic [W+1:0]                      w_diff;
    logic                              w_ge;
    logic                              w_wr_en;
    logic [frbc_pkg::RF_ADDR_W-1:0]    w_wr_addr;
    logic [W-1:0]                      w_wr_data;
    logic [1:0]                        w_kind;
    logic [W-1:0]                      w_value;

    // Operand selection from the held instruction.
    assign w_op  = frbc_pkg::decode(r_instr);
    assign w_dst = r_instr[3:2];
    assign w_src = r_instr[1:0];
    assign w_opa = r_rf[w_dst];
    assign w_opb = r_rf[w_src];

    // Restoring divide trial subtraction.
    assign w_shift = {r_hi, r_lo[W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_opnd};
    assign w_ge    = !w_diff[W+1];

    // Instruction capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_instr    <= i_instr_byte;
            r_in_value <= i_in_value;
        end
    end

    // Shared shift unit: MSB-first multiply or restoring divide, one bit per step.
    always_ff @(posedge i_clk) begin
        if (i_cmd.init_iter) begin
            r_hi   <= '0;
            r_lo   <= w_opa;
            r_opnd <= w_opb;
        end else if (i_cmd.step) begin
            if (w_op == frbc_pkg::OP_MUL) begin
                r_hi <= {r_hi[W-2:0], 1'b0} + (r_lo[W-1] ? r_opnd : '0);
                r_lo <= {r_lo[W-2:0], 1'b0};
            end else begin
                r_hi <= w_ge ? w_diff[W-1:0] : w_shift[W-1:0];
                r_lo <= {r_lo[W-2:0], w_ge};
            end
        end
    end

    // Write-back and report selection.
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = w_dst;
        w_wr_data = '0;
        w_kind    = frbc_pkg::KIND_NONE;
        w_value   = '0;
        case (w_op)
            frbc_pkg::OP_MOVI: begin
                w_wr_en   = 1'b1;
                w_wr_addr = frbc_pkg::MOVI_DST;
                w_wr_data = {1'b0, r_instr[6:0]};
            end
            frbc_pkg::OP_ADD: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_opa + w_opb;
            end
            frbc_pkg::OP_SUB: begin
                w_wr_en   = 1'b1;
                w_wr_data = w_opa - w_opb;
            end
            frbc_pkg::OP_MUL: begin
                w_wr_en   = 1'b1;
                w_wr_data = r_hi;
            end
            frbc_pkg::OP_DIV: begin
                // A zero divisor leaves all quotient bits set.
                w_wr_en   = 1'b1;
                w_wr_data = r_lo;
            end
            frbc_pkg::OP_IN: begin
                w_wr_en   = 1'b1;
                w_wr_addr = w_src;
                w_wr_data = r_in_value;
            end
            frbc_pkg::OP_OUT: begin
                w_kind  = frbc_pkg::KIND_OUT;
                w_value = w_opb;
            end
            frbc_pkg::OP_ILL: begin
                w_kind = frbc_pkg::KIND_ILLEGAL;
            end
            default: begin
                w_kind = frbc_pkg::KIND_ILLEGAL;
            end
        endcase
    end

    // Register file, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < frbc_pkg::RF_DEPTH; i++) begin
                r_rf[i] <= '0;
            end
        end else if (i_cmd.commit && w_wr_en) begin
            r_rf[w_wr_addr] <= w_wr_data;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_kind  <= w_kind;
            r_out_value <= w_value;
        end
    end

    assign o_stat.op       = w_op;
    assign o_stat.out_busy = r_out_valid && i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_kind      = r_out_kind;
    assign o_out_value     = r_out_value;

    // An illegal instruction reports a zero value.
    a_ill_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && w_op == frbc_pkg::OP_ILL |=>
            r_out_kind == frbc_pkg::KIND_ILLEGAL && r_out_value == '0)
        else $error("illegal instruction reported wrongly");

    // A move-immediate never sets the top bit of its destination.
    a_movi_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && w_op == frbc_pkg::OP_MOVI |=> !r_rf[frbc_pkg::MOVI_DST][W-1])
        else $error("move-immediate wrote bit 7");

    // A commit always presents a beat on the next cycle.
    a_commit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |=> r_out_valid)
        else $error("committed result not presented");

endmodule

### rtl/four_register_byte_cpu_top.sv
// The result beat is registered: an accepted move, add, sub, in, out or illegal byte passes
// through the execute and retire states before it is presented; multiply and divide also run
// the 8-step shift unit in between. One instruction at a time: the next beat is taken once
// the previous retires, and retire waits while the output beat is still held by a stall.
// Reset (synchronous, active low) clears all four registers and drops the output beat.
module four_register_byte_cpu_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_instr_byte,
    input  logic [7:0] i_in_value,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_out_kind,
    output logic [7:0] o_out_value
);

    frbc_pkg::t_dp_cmd  w_cmd;
    frbc_pkg::t_dp_stat w_stat;

    // Sequencer.
    frbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Registers, arithmetic and output stage.
    frbc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_instr_byte (i_instr_byte),
        .i_in_value   (i_in_value),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_kind   (o_out_kind),
        .o_out_value  (o_out_value)
    );

endmodule
